### hw/rtl/arcl_pkg.sv
// Package for the LFU result cache: sizes, opcodes and cell control types.
// No dependencies.
package arcl_pkg;
  localparam int ENTRIES   = 64;
  localparam int KEY_BITS  = 32;
  localparam int USE_BITS  = 16;
  localparam int IDX_BITS  = $clog2(ENTRIES);
  localparam int NODE_BITS = 16;
  localparam int VAL_BITS  = 32;
  localparam int TOT_BITS  = 32;
  localparam int SLOT_BITS = 6;

  localparam logic [1:0] OP_LOOKUP   = 2'd0;
  localparam logic [1:0] OP_INSERT   = 2'd1;
  localparam logic [1:0] OP_INV_ALL  = 2'd2;
  localparam logic [1:0] OP_INV_NODE = 2'd3;

  typedef struct packed {
    logic                 bump;
    logic                 write;
    logic                 set_key;
    logic                 clr_all;
    logic                 clr_node;
    logic [KEY_BITS-1:0]  key;
    logic [NODE_BITS-1:0] node;
    logic [VAL_BITS-1:0]  value;
  } arcl_cmd_t;

  typedef struct packed {
    logic                 valid;
    logic                 match;
    logic [USE_BITS-1:0]  uses;
    logic [VAL_BITS-1:0]  value;
  } arcl_stat_t;
endpackage

### hw/rtl/arcl_cell.sv
// One cache entry: key, node, value, use count and valid bit.
// Depends on arcl_pkg.
module arcl_cell import arcl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       sel,
  input  arcl_cmd_t  cmd,
  output arcl_stat_t stat
);
  logic                 valid_r;
  logic [KEY_BITS-1:0]  key_r;
  logic [NODE_BITS-1:0] node_r;
  logic [VAL_BITS-1:0]  value_r;
  logic [USE_BITS-1:0]  uses_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.clr_all) begin
      valid_r <= 1'b0;
    end else if (cmd.clr_node && valid_r && node_r == cmd.node) begin
      valid_r <= 1'b0;
    end else if (sel && cmd.write) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sel && cmd.write) begin
      if (cmd.set_key) key_r <= cmd.key;
      node_r  <= cmd.node;
      value_r <= cmd.value;
      uses_r  <= '0;
    end else if (sel && cmd.bump && uses_r != {USE_BITS{1'b1}}) begin
      uses_r <= uses_r + 1'b1;
    end
  end

  assign stat.valid = valid_r;
  assign stat.match = valid_r && key_r == cmd.key;
  assign stat.uses  = uses_r;
  assign stat.value = value_r;
endmodule

### hw/rtl/arcl_scan.sv
// Priority search over cell status: first match, first free, least used.
// Binary tree of log2(ENTRIES) levels, lower slot wins at every node; ENTRIES is
// a power of two. Combinational, registered by the caller. Depends on arcl_pkg.
module arcl_scan import arcl_pkg::*; (
  input  arcl_stat_t          stat [ENTRIES],
  output logic                hit,
  output logic [IDX_BITS-1:0] hit_idx,
  output logic [IDX_BITS-1:0] victim_idx
);
  localparam int NODES = 2 * ENTRIES - 1;

  logic                t_hit  [NODES];
  logic                t_free [NODES];
  logic [IDX_BITS-1:0] t_hidx [NODES];
  logic [IDX_BITS-1:0] t_fidx [NODES];
  logic [IDX_BITS-1:0] t_midx [NODES];
  logic [USE_BITS-1:0] t_use  [NODES];

  for (genvar i = 0; i < ENTRIES; i++) begin : g_leaf
    assign t_hit[ENTRIES-1+i]  = stat[i].match;
    assign t_free[ENTRIES-1+i] = !stat[i].valid;
    assign t_hidx[ENTRIES-1+i] = IDX_BITS'(i);
    assign t_fidx[ENTRIES-1+i] = IDX_BITS'(i);
    assign t_midx[ENTRIES-1+i] = IDX_BITS'(i);
    assign t_use[ENTRIES-1+i]  = stat[i].uses;
  end

  for (genvar n = 0; n < ENTRIES - 1; n++) begin : g_node
    assign t_hit[n]  = t_hit[2*n+1] || t_hit[2*n+2];
    assign t_hidx[n] = t_hit[2*n+1] ? t_hidx[2*n+1] : t_hidx[2*n+2];
    assign t_free[n] = t_free[2*n+1] || t_free[2*n+2];
    assign t_fidx[n] = t_free[2*n+1] ? t_fidx[2*n+1] : t_fidx[2*n+2];
    assign t_use[n]  = (t_use[2*n+2] < t_use[2*n+1]) ? t_use[2*n+2] : t_use[2*n+1];
    assign t_midx[n] = (t_use[2*n+2] < t_use[2*n+1]) ? t_midx[2*n+2] : t_midx[2*n+1];
  end

  assign hit        = t_hit[0];
  assign hit_idx    = t_hidx[0];
  assign victim_idx = t_free[0] ? t_fidx[0] : t_midx[0];
endmodule

### hw/rtl/assoc_result_cache_lfu_core.sv
// Top level of the LFU result cache: request capture, cell row, search, result.
// Depends on arcl_pkg, arcl_cell, arcl_scan.
//
// Every request is registered at the accepting edge; in the next cycle all
// 64 cells compare their keys, the search picks a slot and the chosen cell
// is written at the end of that cycle; the result is shown with out_valid in
// the cycle after. busy is high only during the search cycle, so a new request
// cannot be taken then but may be accepted in the cycle that shows the
// previous result. Results cannot be held off.
module assoc_result_cache_lfu_core import arcl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_opcode,
  input  logic [31:0]           in_key,
  input  logic signed [15:0]    in_node_tag,
  input  logic [31:0]           in_value,
  output logic                  out_valid,
  output logic                  out_hit,
  output logic [31:0]           out_found_value,
  output logic [SLOT_BITS-1:0]  out_slot,
  output logic [TOT_BITS-1:0]   out_hit_total,
  output logic [TOT_BITS-1:0]   out_miss_total
);
  logic                 pend_r;
  logic [1:0]           op_r;
  logic [KEY_BITS-1:0]  key_r;
  logic [NODE_BITS-1:0] node_r;
  logic [VAL_BITS-1:0]  val_r;
  logic [TOT_BITS-1:0]  hits_r, misses_r;

  arcl_cmd_t           cmd;
  arcl_stat_t          stat [ENTRIES];
  logic                hit;
  logic [IDX_BITS-1:0] hit_idx, victim_idx, sel_idx;
  logic                is_lu, is_ins;

  assign busy   = pend_r;
  assign is_lu  = pend_r && op_r == OP_LOOKUP;
  assign is_ins = pend_r && op_r == OP_INSERT && val_r != '0;

  always_ff @(posedge clk) begin
    if (!rst_n) pend_r <= 1'b0;
    else        pend_r <= start && !busy;
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_r   <= in_opcode;
      key_r  <= KEY_BITS'(in_key);
      node_r <= in_node_tag;
      val_r  <= in_value;
    end
  end

  always_comb begin
    cmd.bump     = is_lu && hit;
    cmd.write    = is_ins;
    cmd.set_key  = !hit;
    cmd.clr_all  = pend_r && op_r == OP_INV_ALL;
    cmd.clr_node = pend_r && op_r == OP_INV_NODE;
    cmd.key      = key_r;
    cmd.node     = node_r;
    cmd.value    = val_r;
  end

  assign sel_idx = hit ? hit_idx : victim_idx;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    arcl_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .sel  (sel_idx == IDX_BITS'(g)),
      .cmd  (cmd),
      .stat (stat[g])
    );
  end

  arcl_scan u_scan (
    .stat      (stat),
    .hit       (hit),
    .hit_idx   (hit_idx),
    .victim_idx(victim_idx)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r <= '0; misses_r <= '0; out_valid <= 1'b0;
    end else begin
      out_valid <= pend_r;
      if (is_lu && hit && hits_r != '1) hits_r <= hits_r + 1'b1;
      if (is_lu && !hit && misses_r != '1) misses_r <= misses_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_r) begin
      out_hit         <= (is_lu || is_ins) && hit;
      out_found_value <= (is_lu && hit) ? stat[hit_idx].value : '0;
      out_slot        <= ((is_lu && hit) || is_ins) ? SLOT_BITS'(sel_idx) : '0;
    end
  end

  assign out_hit_total  = hits_r;
  assign out_miss_total = misses_r;

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid) else $error("missing result");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy) else $error("busy too long");
  a_hits_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> hits_r >= $past(hits_r)) else $error("hit total fell");
endmodule

### tb/assoc_result_cache_lfu_core_tb.sv
// Testbench for the LFU result cache core: bursty request driver, per-cycle
// result monitor and a cycle-free cache predictor checked field by field.
// Depends on arcl_pkg and assoc_result_cache_lfu_core.
`timescale 1ns / 1ps

module assoc_result_cache_lfu_core_tb;
  import arcl_pkg::*;

  typedef struct {
    logic              pause;
    logic [1:0]        opcode;
    logic [31:0]       key;
    logic [15:0]       node;
    logic [31:0]       value;
  } request_t;

  typedef struct {
    logic              hit;
    logic [31:0]       found_value;
    logic [SLOT_BITS-1:0] slot;
    logic [31:0]       hit_total;
    logic [31:0]       miss_total;
  } answer_t;

  logic clk, rst_n, start, busy;
  logic [1:0] in_opcode;
  logic [31:0] in_key;
  logic signed [15:0] in_node_tag;
  logic [31:0] in_value;
  logic out_valid, out_hit;
  logic [31:0] out_found_value;
  logic [SLOT_BITS-1:0] out_slot;
  logic [TOT_BITS-1:0] out_hit_total, out_miss_total;

  assoc_result_cache_lfu_core DUT (.*);

  request_t pending_reqs[$];
  answer_t  expected_answers[$];
  int       errors = 0;
  logic     taken = 1'b0;
  logic     drain_wait = 1'b0;
  int       gap_left = 0;
  int       burst_left = 1;

  // cache mirror
  logic        c_valid[ENTRIES];
  logic [31:0] c_key[ENTRIES];
  logic [15:0] c_node[ENTRIES];
  logic [31:0] c_value[ENTRIES];
  logic [USE_BITS-1:0] c_uses[ENTRIES];
  logic [31:0] c_hits, c_misses;

  logic [31:0] key_pool[80];
  logic [15:0] node_pool[6];

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  function automatic int find_entry(logic [31:0] k);
    for (int i = 0; i < ENTRIES; i++)
      if (c_valid[i] && c_key[i] == k) return i;
    return -1;
  endfunction

  function automatic int choose_victim();
    int best;
    best = 0;
    for (int i = 0; i < ENTRIES; i++)
      if (!c_valid[i]) return i;
    for (int i = 1; i < ENTRIES; i++)
      if (c_uses[i] < c_uses[best]) best = i;
    return best;
  endfunction

  function automatic answer_t cache_apply(request_t r);
    answer_t a;
    int idx;
    a = '{1'b0, 32'd0, '0, 32'd0, 32'd0};
    case (r.opcode)
      OP_LOOKUP: begin
        idx = find_entry(r.key);
        if (idx >= 0) begin
          if (c_uses[idx] != '1) c_uses[idx]++;
          if (c_hits != 32'hFFFF_FFFF) c_hits++;
          a.hit = 1'b1;
          a.found_value = c_value[idx];
          a.slot = idx[SLOT_BITS-1:0];
        end else if (c_misses != 32'hFFFF_FFFF) begin
          c_misses++;
        end
      end
      OP_INSERT: begin
        if (r.value != 0) begin
          idx = find_entry(r.key);
          if (idx >= 0) a.hit = 1'b1;
          else begin
            idx = choose_victim();
            c_key[idx] = r.key;
            c_valid[idx] = 1'b1;
          end
          c_value[idx] = r.value;
          c_node[idx] = r.node;
          c_uses[idx] = '0;
          a.slot = idx[SLOT_BITS-1:0];
        end
      end
      OP_INV_ALL: begin
        for (int i = 0; i < ENTRIES; i++) c_valid[i] = 1'b0;
      end
      default: begin
        for (int i = 0; i < ENTRIES; i++)
          if (c_valid[i] && c_node[i] == r.node) c_valid[i] = 1'b0;
      end
    endcase
    a.hit_total = c_hits;
    a.miss_total = c_misses;
    return a;
  endfunction

  // result check first, then capture of the accepted request
  always @(posedge clk) begin
    answer_t e;
    request_t r;
    if (out_valid) begin
      if (expected_answers.size() == 0) begin
        $error("unexpected result");
        errors++;
      end else begin
        e = expected_answers.pop_front();
        if (out_hit !== e.hit) begin
          $error("hit exp %0h got %0h", e.hit, out_hit); errors++;
        end
        if (out_found_value !== e.found_value) begin
          $error("found_value exp %0h got %0h", e.found_value, out_found_value); errors++;
        end
        if (out_slot !== e.slot) begin
          $error("slot exp %0d got %0d", e.slot, out_slot); errors++;
        end
        if (out_hit_total !== e.hit_total) begin
          $error("hit_total exp %0d got %0d", e.hit_total, out_hit_total); errors++;
        end
        if (out_miss_total !== e.miss_total) begin
          $error("miss_total exp %0d got %0d", e.miss_total, out_miss_total); errors++;
        end
      end
    end
    if (rst_n && start && !busy) begin
      r = '{1'b0, in_opcode, in_key, in_node_tag, in_value};
      expected_answers.push_back(cache_apply(r));
      taken <= 1'b1;
    end else begin
      taken <= 1'b0;
    end
  end

  always @(negedge clk) begin
    request_t r;
    if (rst_n && !(start && !taken)) begin
      if (drain_wait) begin
        start <= 1'b0;
        if (expected_answers.size() == 0) drain_wait = 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        r = pending_reqs.pop_front();
        if (r.pause) begin
          drain_wait = 1'b1;
          start <= 1'b0;
        end else begin
          in_opcode <= r.opcode;
          in_key <= r.key;
          in_node_tag <= r.node;
          in_value <= r.value;
          start <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
          end
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic add_req(logic [1:0] op, logic [31:0] k, logic [15:0] n, logic [31:0] v);
    pending_reqs.push_back('{1'b0, op, k, n, v});
  endtask

  task automatic add_pause();
    pending_reqs.push_back('{1'b1, OP_LOOKUP, 32'd0, 16'd0, 32'd0});
  endtask

  task automatic add_random_req();
    int pick;
    logic [31:0] k, v;
    pick = $urandom_range(0, 99);
    k = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, 79)];
    v = ($urandom_range(0, 15) == 0) ? 32'd0 : $urandom;
    if (pick < 50)      add_req(OP_LOOKUP, k, node_pool[$urandom_range(0, 5)], $urandom);
    else if (pick < 88) add_req(OP_INSERT, k, node_pool[$urandom_range(0, 5)], v);
    else if (pick < 98) add_req(OP_INV_NODE, k, node_pool[$urandom_range(0, 5)], $urandom);
    else                add_req(OP_INV_ALL, $urandom, 16'($urandom_range(0, 32767)), $urandom);
  endtask

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      c_valid[i] = 1'b0; c_key[i] = '0; c_node[i] = '0; c_value[i] = '0; c_uses[i] = '0;
    end
    c_hits = 0;
    c_misses = 0;
    for (int i = 0; i < 80; i++) key_pool[i] = $urandom;
    key_pool[0] = 32'd0;
    key_pool[1] = 32'hFFFF_FFFF;
    node_pool = '{16'hFFFF, 16'h0000, 16'h7FFF, 16'h0001, 16'h1234, 16'h0042};

    // directed
    add_req(OP_LOOKUP, 32'd0, 16'hFFFF, 32'd0);
    add_req(OP_INSERT, 32'd5, 16'h0001, 32'd0);
    add_req(OP_INSERT, 32'd0, 16'h7FFF, 32'hFFFF_FFFF);
    add_req(OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 32'd1);
    add_req(OP_LOOKUP, 32'd0, 16'h0000, 32'd0);
    add_req(OP_LOOKUP, 32'hFFFF_FFFF, 16'h0000, 32'hFFFF_FFFF);
    add_req(OP_INSERT, 32'd0, 16'h0000, 32'hA5A5_5A5A);
    add_req(OP_LOOKUP, 32'd0, 16'h0000, 32'd0);
    add_req(OP_INV_NODE, 32'd0, 16'h1234, 32'd0);
    add_req(OP_INV_NODE, 32'd0, 16'hFFFF, 32'd0);
    add_req(OP_LOOKUP, 32'hFFFF_FFFF, 16'h0000, 32'd0);
    add_req(OP_LOOKUP, 32'd0, 16'h0000, 32'd0);
    add_req(OP_INV_ALL, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    add_req(OP_LOOKUP, 32'd0, 16'h0000, 32'd0);
    add_pause();

    // fill every slot, use all but slot 7, then evict
    for (int i = 0; i < ENTRIES; i++) add_req(OP_INSERT, 32'h100 + i, 16'h0042, i + 1);
    for (int i = 0; i < ENTRIES; i++)
      if (i != 7) add_req(OP_LOOKUP, 32'h100 + i, 16'h0000, 32'd0);
    add_req(OP_INSERT, 32'hDEAD_BEEF, 16'h0001, 32'h1);
    add_req(OP_INSERT, 32'hDEAD_BEE0, 16'h0001, 32'h2);
    add_req(OP_INV_NODE, 32'd0, 16'h0042, 32'd0);
    add_pause();

    for (int i = 0; i < 1800; i++) begin
      add_random_req();
      if (i == 900) add_pause();
    end

    // one heavily used entry, then evict around it
    add_req(OP_INV_ALL, 32'd0, 16'h0000, 32'd0);
    add_req(OP_INSERT, 32'h5A5A_0001, 16'h0001, 32'h77);
    for (int i = 0; i < 20; i++) add_req(OP_LOOKUP, 32'h5A5A_0001, 16'h0000, 32'd0);
    for (int i = 1; i < ENTRIES + 2; i++) add_req(OP_INSERT, 32'h300 + i, 16'h0001, i);
    add_req(OP_LOOKUP, 32'h5A5A_0001, 16'h0000, 32'd0);

    start = 1'b0;
    in_opcode = OP_LOOKUP;
    in_key = '0;
    in_node_tag = '0;
    in_value = '0;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    wait (pending_reqs.size() == 0 && !drain_wait);
    @(negedge clk);
    wait (!start && expected_answers.size() == 0);
    repeat (10) @(posedge clk);
    if (errors == 0 && expected_answers.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule

### filelist.f
hw/rtl/arcl_pkg.sv
hw/rtl/arcl_cell.sv
hw/rtl/arcl_scan.sv
hw/rtl/assoc_result_cache_lfu_core.sv
tb/assoc_result_cache_lfu_core_tb.sv
